// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== hw/rtl/pns_pkg.sv =====
// Shared types and constants of the PWM note sequencer.
`timescale 1ns / 1ps
package pns_pkg;

  localparam int MAX_NOTES_DEF = 64;
  localparam int ELAPSED_W     = 33;
  localparam int NOTE_IDX_W    = 6;
  localparam int ENTRY_W       = 96;
  localparam int IN_TDATA_W    = 104;
  localparam int OUT_TDATA_W   = 48;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_PAUSED  = 2'd1,
    MODE_PLAYING = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LOAD,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic eval;
    logic load;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic play_go;
    logic need_load;
  } dp_sts_t;

endpackage

// ===== hw/rtl/pns_ctrl.sv =====
// Sequencing controller: input/output handshake and work states.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pns_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output pns_pkg::dp_cmd_t cmd,
  input  pns_pkg::dp_sts_t sts
);
  import pns_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  // no transfer is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.accept = in_xfer;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = sts.play_go ? S_EVAL : S_DONE;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.need_load ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // result slot frees when empty or drained this cycle
        if (!out_valid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  `ASSERT_CLK(a_one_at_a_time, in_xfer |=> !in_tready, "item accepted while busy")
  `ASSERT_CLK(a_load_after_eval, (state_r == S_LOAD) |-> ($past(state_r) == S_EVAL),
              "note load without evaluation")
  `ASSERT_CLK(a_emit_shows, cmd.emit |=> out_tvalid, "emitted result not presented")

endmodule

// ===== hw/rtl/pns_dp.sv =====
// Datapath: note table memory, player registers and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pns_dp #(
  parameter int MAX_NOTES = pns_pkg::MAX_NOTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pns_pkg::dp_cmd_t                   cmd,
  output pns_pkg::dp_sts_t                   sts,
  input  logic [pns_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [1:0]                         in_tuser,
  output logic [pns_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import pns_pkg::*;

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W = $clog2(MAX_NOTES + 1);

  // table entry: gap, length, period, compare (high to low)
  logic [ENTRY_W-1:0] mem [MAX_NOTES];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     next_index_r, next_index_nxt;
  logic [IDX_W-1:0]     cur_index_r, cur_index_nxt;
  logic                 have_cur_r, have_cur_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  mode_t                mode_r, mode_nxt, mode_ap;
  mode_t                pending_r, pending_nxt;
  logic [15:0]          compare_r, compare_nxt;
  logic [15:0]          reload_r, reload_nxt;
  logic                 pwm_r, pwm_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [IDX_W-1:0]     load_idx;
  logic [CNT_W-1:0]     idx_inc;
  logic [IDX_W-1:0]     after_idx;
  logic [ELAPSED_W-1:0] len_ext, end_time;
  logic                 full, do_load, sounding, in_note;
  logic [1:0]           req;

  assign req      = in_tdata[97:96];
  assign full     = (count_r >= CNT_W'(MAX_NOTES));
  assign wr_en    = cmd.accept && (in_tuser == OP_APPEND) && !full;
  assign load_idx = (CNT_W'(next_index_r) >= count_r) ? '0 : next_index_r;
  assign idx_inc  = CNT_W'(load_idx) + CNT_W'(1);
  assign after_idx = (idx_inc >= count_r) ? '0 : idx_inc[IDX_W-1:0];
  assign rd_addr  = (cmd.accept && have_cur_r) ? cur_index_r : load_idx;

  assign len_ext  = {1'b0, rd_data_r[63:32]};
  assign end_time = len_ext + {1'b0, rd_data_r[95:64]};
  assign sounding = (elapsed_r < len_ext);
  assign in_note  = (elapsed_r < end_time);
  assign do_load  = cmd.load || (cmd.eval && !have_cur_r);

  // mode once the pending request is applied on a tick
  always_comb begin
    mode_ap = mode_r;
    if (pending_r != mode_r) begin
      unique case (pending_r)
        MODE_IDLE:    mode_ap = MODE_IDLE;
        MODE_PAUSED:  mode_ap = (mode_r == MODE_PLAYING) ? MODE_PAUSED : mode_r;
        MODE_PLAYING: mode_ap = MODE_PLAYING;
        default:      mode_ap = mode_r;
      endcase
    end
  end

  assign sts.play_go   = (in_tuser == OP_TICK) && (count_r != '0) &&
                         (mode_ap == MODE_PLAYING);
  assign sts.need_load = have_cur_r && !in_note;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= in_tdata[ENTRY_W-1:0];
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt      = count_r;
    next_index_nxt = next_index_r;
    cur_index_nxt  = cur_index_r;
    have_cur_nxt   = have_cur_r;
    elapsed_nxt    = elapsed_r;
    mode_nxt       = mode_r;
    pending_nxt    = pending_r;
    compare_nxt    = compare_r;
    reload_nxt     = reload_r;
    pwm_nxt        = pwm_r;

    if (cmd.accept) begin
      unique case (in_tuser)
        OP_TICK: begin
          if (elapsed_r != '1) begin
            elapsed_nxt = elapsed_r + ELAPSED_W'(1);
          end
          if (count_r != '0 && pending_r != mode_r) begin
            mode_nxt = mode_ap;
            unique case (pending_r)
              MODE_IDLE: begin
                count_nxt      = '0;
                next_index_nxt = '0;
                have_cur_nxt   = 1'b0;
                pwm_nxt        = 1'b0;
              end
              MODE_PAUSED: begin
                if (mode_r == MODE_PLAYING) begin
                  compare_nxt = '0;
                end
              end
              MODE_PLAYING: begin
                if (mode_r == MODE_IDLE) begin
                  pwm_nxt     = 1'b1;
                  compare_nxt = '0;
                end
              end
              default: ;
            endcase
          end
        end
        OP_APPEND: begin
          if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_REQUEST: begin
          if (req <= MODE_PLAYING) begin
            pending_nxt = mode_t'(req);
          end
        end
        default: ;
      endcase
    end

    if (do_load) begin
      cur_index_nxt  = load_idx;
      have_cur_nxt   = 1'b1;
      compare_nxt    = rd_data_r[15:0];
      reload_nxt     = rd_data_r[31:16];
      elapsed_nxt    = '0;
      next_index_nxt = after_idx;
    end else if (cmd.eval) begin
      if (sounding) begin
        compare_nxt = rd_data_r[15:0];
      end else if (in_note) begin
        compare_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_index_r <= '0;
      cur_index_r  <= '0;
      have_cur_r   <= 1'b0;
      elapsed_r    <= '0;
      mode_r       <= MODE_IDLE;
      pending_r    <= MODE_IDLE;
      compare_r    <= '0;
      reload_r     <= '0;
      pwm_r        <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      next_index_r <= next_index_nxt;
      cur_index_r  <= cur_index_nxt;
      have_cur_r   <= have_cur_nxt;
      elapsed_r    <= elapsed_nxt;
      mode_r       <= mode_nxt;
      pending_r    <= pending_nxt;
      compare_r    <= compare_nxt;
      reload_r     <= reload_nxt;
      pwm_r        <= pwm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {7'd0, NOTE_IDX_W'(cur_index_r), mode_r, pwm_r, reload_r, compare_r};
    end
  end

  assign out_tdata = out_tdata_r;

  `ASSERT_NEVER(a_count_bound, count_r > CNT_W'(MAX_NOTES), "note count above table size")
  `ASSERT_CLK(a_cur_in_table, have_cur_r |-> (CNT_W'(cur_index_r) < count_r),
              "current note outside stored notes")

endmodule

// ===== hw/rtl/pwm_note_sequencer.sv =====
// Append/request go from accept straight to the done state, as does a tick when
// not playing; a playing tick evaluates first (loading the first note there),
// then loads when a note hands over. One item at a time; the note table read is
// registered (one read to check the note, one more to load the next).
// Reset: synchronous active-low rst_n; table contents are not cleared, the note
// count, indices, timers, mode and PWM registers reset to zero/idle.
`timescale 1ns / 1ps
module pwm_note_sequencer #(
  parameter int MAX_NOTES = pns_pkg::MAX_NOTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pitch_compare[15:0], pitch_period[31:16], note_length[63:32],
  // gap_length[95:64], requested_state[97:96], zero pad
  input  logic [pns_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // compare_value[15:0], reload_value[31:16], pwm_running[32],
  // player_state[34:33], note_index[40:35], zero pad
  output logic [pns_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pns_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  pns_dp #(
    .MAX_NOTES (MAX_NOTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata)
  );

endmodule
